// ----- hw/rtl/lfdc_pkg.sv -----
`default_nettype none

package lfdc_pkg;

    // drive command codes
    localparam logic [2:0] CMD_STOP  = 3'd0;
    localparam logic [2:0] CMD_RUN   = 3'd1;
    localparam logic [2:0] CMD_RIGHT = 3'd2;
    localparam logic [2:0] CMD_LEFT  = 3'd3;
    localparam logic [2:0] CMD_HOLD  = 3'd4;

    // sensor pattern classes, decided by the front end
    localparam logic [2:0] CLS_RUN_ST  = 3'd0;  // both outers black, no correction
    localparam logic [2:0] CLS_RUN_NR  = 3'd1;  // inner left white: nudge right
    localparam logic [2:0] CLS_RUN_NL  = 3'd2;  // inner right white: nudge left
    localparam logic [2:0] CLS_CROSS   = 3'd3;  // crossing
    localparam logic [2:0] CLS_START_R = 3'd4;  // outer right white alone
    localparam logic [2:0] CLS_START_L = 3'd5;  // outer left white alone
    localparam logic [2:0] CLS_NONE    = 3'd6;  // all outers white, inners black

    // configuration register indexes
    localparam logic [2:0] CFG_UPPER_SPEED   = 3'd0;
    localparam logic [2:0] CFG_LOWER_SPEED   = 3'd1;
    localparam logic [2:0] CFG_SPEED_STEP    = 3'd2;
    localparam logic [2:0] CFG_STOP_DISTANCE = 3'd3;
    localparam logic [2:0] CFG_CROSS_LIMIT   = 3'd4;

    localparam logic [7:0]  RST_UPPER_SPEED   = 8'd150;
    localparam logic [7:0]  RST_LOWER_SPEED   = 8'd80;
    localparam logic [7:0]  RST_SPEED_STEP    = 8'd4;
    localparam logic [10:0] RST_STOP_DISTANCE = 11'd8;
    localparam logic [3:0]  RST_CROSS_LIMIT   = 4'd6;
    localparam logic [7:0]  RST_WHEEL_SPEED   = 8'd120;
    localparam logic [3:0]  CROSS_MAX         = 4'd15;

    typedef struct packed {
        logic       stop;
        logic [2:0] cls;
        logic       il;
        logic       ir;
    } t_item;

    typedef struct packed {
        logic [7:0] upper_speed;
        logic [7:0] lower_speed;
        logic [7:0] speed_step;
        logic [3:0] cross_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] l;
        logic [7:0] r;
    } t_speeds;

    function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic [7:0] sat_sub(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : 8'd0;
    endfunction

    // to_right: left rises, right falls; otherwise the mirror
    function automatic t_speeds nudge(input t_speeds s, input logic to_right, input t_cfg c);
        t_speeds n;
        n = s;
        if (to_right) begin
            if (s.r > c.lower_speed) n.r = sat_sub(s.r, c.speed_step);
            if (s.l < c.upper_speed) n.l = sat_add(s.l, c.speed_step);
        end else begin
            if (s.r < c.upper_speed) n.r = sat_add(s.r, c.speed_step);
            if (s.l > c.lower_speed) n.l = sat_sub(s.l, c.speed_step);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lfdc_in_if.sv -----
`default_nettype none

interface lfdc_in_if;
    logic        valid;
    logic        ready;
    logic        outer_left_white;
    logic        inner_left_white;
    logic        inner_right_white;
    logic        outer_right_white;
    logic [10:0] distance_cm;

    modport source (
        output valid, outer_left_white, inner_left_white, inner_right_white,
               outer_right_white, distance_cm,
        input  ready
    );
    modport sink (
        input  valid, outer_left_white, inner_left_white, inner_right_white,
               outer_right_white, distance_cm,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/lfdc_out_if.sv -----
`default_nettype none

interface lfdc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] drive_cmd;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [3:0] crossings;

    modport source (
        output valid, drive_cmd, left_speed, right_speed, crossings,
        input  ready
    );
    modport sink (
        input  valid, drive_cmd, left_speed, right_speed, crossings,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/line_follower_drive_controller_core.sv -----
// Path: a word accepted on the input is written into the queue, then popped by
//   the back end into its output register, from which it shows on the output channel.
// Throughput: one word per cycle while the output channel takes words; the back end updates its state as it pops each.
// Reset (synchronous, active low): queue and output empty, wheel speeds 120,
//   no turn, crossing count 0, configuration registers to their defaults.
`default_nettype none

module line_follower_drive_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_wdata,
    lfdc_in_if.sink          i_in,
    lfdc_out_if.source       o_out
);

    // Configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [7:0]  r_upper_speed;
    logic [7:0]  r_lower_speed;
    logic [7:0]  r_speed_step;
    logic [10:0] r_stop_distance;
    logic [3:0]  r_cross_limit;

    lfdc_pkg::t_cfg  cfg;
    lfdc_pkg::t_item front_item, q_item;
    logic            front_push, q_ready, q_valid, back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_speed   <= lfdc_pkg::RST_UPPER_SPEED;
            r_lower_speed   <= lfdc_pkg::RST_LOWER_SPEED;
            r_speed_step    <= lfdc_pkg::RST_SPEED_STEP;
            r_stop_distance <= lfdc_pkg::RST_STOP_DISTANCE;
            r_cross_limit   <= lfdc_pkg::RST_CROSS_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lfdc_pkg::CFG_UPPER_SPEED:   r_upper_speed   <= i_cfg_wdata[7:0];
                lfdc_pkg::CFG_LOWER_SPEED:   r_lower_speed   <= i_cfg_wdata[7:0];
                lfdc_pkg::CFG_SPEED_STEP:    r_speed_step    <= i_cfg_wdata[7:0];
                lfdc_pkg::CFG_STOP_DISTANCE: r_stop_distance <= i_cfg_wdata;
                lfdc_pkg::CFG_CROSS_LIMIT:   r_cross_limit   <= i_cfg_wdata[3:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg.upper_speed = r_upper_speed;
    assign cfg.lower_speed = r_lower_speed;
    assign cfg.speed_step  = r_speed_step;
    assign cfg.cross_limit = r_cross_limit;

    // Front end: stop test and sensor pattern, no dependence on drive state
    lfdc_front u_front (
        .i_in            (i_in),
        .i_stop_distance (r_stop_distance),
        .i_q_ready       (q_ready),
        .o_item          (front_item),
        .o_push          (front_push)
    );

    // Short queue so either side can stall alone
    lfdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (back_pop)
    );

    // Back end: turns, crossings, wheel speeds; output register doubles as skid
    lfdc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (back_pop),
        .i_cfg   (cfg),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/lfdc_front.sv -----
`default_nettype none

// Classifies each sensor word; state-free, and waits only when the queue is full.
module lfdc_front (
    lfdc_in_if.sink            i_in,
    input  wire logic [10:0]   i_stop_distance,
    input  wire logic          i_q_ready,
    output lfdc_pkg::t_item    o_item,
    output logic               o_push
);

    logic ol, il, ir, orr;

    assign ol  = i_in.outer_left_white;
    assign il  = i_in.inner_left_white;
    assign ir  = i_in.inner_right_white;
    assign orr = i_in.outer_right_white;

    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid && i_q_ready;

    always_comb begin
        o_item.stop = (i_in.distance_cm <= i_stop_distance);
        o_item.il   = il;
        o_item.ir   = ir;
        if (!ol && !orr) begin
            if (il && !ir)      o_item.cls = lfdc_pkg::CLS_RUN_NR;
            else if (!il && ir) o_item.cls = lfdc_pkg::CLS_RUN_NL;
            else                o_item.cls = lfdc_pkg::CLS_RUN_ST;
        end else if (ol && orr && (il || ir)) begin
            o_item.cls = lfdc_pkg::CLS_CROSS;
        end else if (!ol && orr) begin
            o_item.cls = lfdc_pkg::CLS_START_R;
        end else if (ol && !orr) begin
            o_item.cls = lfdc_pkg::CLS_START_L;
        end else begin
            o_item.cls = lfdc_pkg::CLS_NONE;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfdc_queue.sv -----
`default_nettype none

// Two-entry queue between front and back end.
module lfdc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lfdc_pkg::t_item  i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output lfdc_pkg::t_item       o_item,
    input  wire logic             i_pop
);

    lfdc_pkg::t_item r_mem [2];
    logic            r_wr_ptr, r_rd_ptr;
    logic [1:0]      r_count, n_count;
    logic            push_ok, pop_ok;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok)      n_count = r_count + 2'd1;
        else if (!push_ok && pop_ok) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) r_wr_ptr <= !r_wr_ptr;
            if (pop_ok)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wr_ptr] <= i_item;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue occupancy out of range");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("queue pointers disagree with occupancy");

endmodule

`default_nettype wire

// ----- hw/rtl/lfdc_back.sv -----
`default_nettype none

// Executes classified words against the drive state; registered result.
module lfdc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire lfdc_pkg::t_item  i_item,
    output logic                  o_pop,
    input  wire lfdc_pkg::t_cfg   i_cfg,
    lfdc_out_if.source            o_out
);

    lfdc_pkg::t_speeds r_sp, n_sp;
    logic              r_lt, n_lt, r_rt, n_rt;
    logic              r_irs, n_irs, r_ils, n_ils;
    logic [3:0]        r_cross, n_cross;
    logic              r_valid;
    logic [2:0]        r_cmd, n_cmd;
    logic [7:0]        r_ls, n_ls, r_rs, n_rs;
    logic [3:0]        r_cnt_out;
    lfdc_pkg::t_speeds sp_a;

    assign o_pop = i_valid && (!r_valid || o_out.ready);

    always_comb begin
        n_sp    = r_sp;
        n_lt    = r_lt;
        n_rt    = r_rt;
        n_irs   = r_irs;
        n_ils   = r_ils;
        n_cross = r_cross;
        n_cmd   = lfdc_pkg::CMD_HOLD;
        n_ls    = 8'd0;
        n_rs    = 8'd0;
        sp_a    = r_sp;
        if (i_item.stop) begin
            n_cmd = lfdc_pkg::CMD_STOP;
        end else if (r_cross >= i_cfg.cross_limit) begin
            n_cmd = lfdc_pkg::CMD_RIGHT;
            n_ls  = i_cfg.upper_speed;
            n_rs  = i_cfg.upper_speed;
        end else if (!r_lt && !r_rt) begin
            case (i_item.cls)
                lfdc_pkg::CLS_RUN_NR, lfdc_pkg::CLS_RUN_NL, lfdc_pkg::CLS_RUN_ST: begin
                    if (i_item.cls == lfdc_pkg::CLS_RUN_NR)
                        n_sp = lfdc_pkg::nudge(r_sp, 1'b1, i_cfg);
                    else if (i_item.cls == lfdc_pkg::CLS_RUN_NL)
                        n_sp = lfdc_pkg::nudge(r_sp, 1'b0, i_cfg);
                    n_cmd = lfdc_pkg::CMD_RUN;
                    n_ls  = n_sp.l;
                    n_rs  = n_sp.r;
                end
                lfdc_pkg::CLS_CROSS: begin
                    if (r_cross != lfdc_pkg::CROSS_MAX) n_cross = r_cross + 4'd1;
                end
                lfdc_pkg::CLS_START_R: begin
                    n_cmd = lfdc_pkg::CMD_RIGHT;
                    n_ls  = i_cfg.lower_speed;
                    n_rs  = i_cfg.lower_speed;
                    n_rt  = 1'b1;
                    n_ils = 1'b0;
                end
                lfdc_pkg::CLS_START_L: begin
                    n_cmd = lfdc_pkg::CMD_LEFT;
                    n_ls  = i_cfg.lower_speed;
                    n_rs  = i_cfg.lower_speed;
                    n_lt  = 1'b1;
                    n_irs = 1'b0;
                end
                default: ;
            endcase
        end else begin
            // left turn first, right turn second, speeds chained between them
            if (r_lt && i_item.ir && !r_irs) begin
                n_irs = 1'b1;
            end else if (r_lt && !i_item.ir && r_irs) begin
                n_irs = 1'b0;
                n_lt  = 1'b0;
                sp_a  = lfdc_pkg::nudge(r_sp, 1'b0, i_cfg);
                n_cmd = lfdc_pkg::CMD_RUN;
                n_ls  = (sp_a.r > sp_a.l) ? sp_a.l : sp_a.r;
                n_rs  = n_ls;
            end
            n_sp = sp_a;
            if (r_rt && i_item.il && !r_ils) begin
                n_ils = 1'b1;
            end else if (r_rt && !i_item.il && r_ils) begin
                n_ils = 1'b0;
                n_rt  = 1'b0;
                n_sp  = lfdc_pkg::nudge(sp_a, 1'b1, i_cfg);
                n_cmd = lfdc_pkg::CMD_RUN;
                n_ls  = (n_sp.r > n_sp.l) ? n_sp.l : n_sp.r;
                n_rs  = n_ls;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '{l: lfdc_pkg::RST_WHEEL_SPEED, r: lfdc_pkg::RST_WHEEL_SPEED};
            r_lt    <= 1'b0;
            r_rt    <= 1'b0;
            r_irs   <= 1'b0;
            r_ils   <= 1'b0;
            r_cross <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_sp    <= n_sp;
                r_lt    <= n_lt;
                r_rt    <= n_rt;
                r_irs   <= n_irs;
                r_ils   <= n_ils;
                r_cross <= n_cross;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd     <= n_cmd;
            r_ls      <= n_ls;
            r_rs      <= n_rs;
            r_cnt_out <= n_cross;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.drive_cmd   = r_cmd;
    assign o_out.left_speed  = r_ls;
    assign o_out.right_speed = r_rs;
    assign o_out.crossings   = r_cnt_out;

    a_one_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_lt && r_rt))
        else $error("left and right turn both active");

    a_cross_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cross == lfdc_pkg::CROSS_MAX) |=> (r_cross == lfdc_pkg::CROSS_MAX))
        else $error("crossing count left saturation");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_cmd == lfdc_pkg::CMD_STOP || r_cmd == lfdc_pkg::CMD_HOLD))
            |-> (r_ls == 8'd0 && r_rs == 8'd0))
        else $error("stop or hold word carries a speed");

    a_seen_needs_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_irs |-> r_lt) and (r_ils |-> r_rt))
        else $error("inner sensor mark set outside a turn");

endmodule

`default_nettype wire
